### design/fcpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fcpu_pkg
// Shared constants and the arctangent table for the fly camera pose update block.
// ---------------------------------------------------------------------------
package fcpu_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [15:0] UNIT_VAL    = 16'sd16384;
    localparam logic signed [16:0] QUARTER     = 17'sd11520;
    localparam logic signed [16:0] PITCH_LIMIT = 17'sd11392;
    localparam logic signed [16:0] YAW_HALF    = 17'sd23040;
    localparam logic signed [17:0] YAW_FULL    = 18'sd46080;
    localparam logic signed [33:0] INV_GAIN    = 34'sd652032874;

    localparam logic REG_MOVE_SPEED = 1'b0;
    localparam logic REG_LOOK_SENS  = 1'b1;

    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_LOOK = 1'b1;

    // arctangent table in 2^-24 degree units
    function automatic logic [31:0] atan_deg24(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'd754974720;
                5'd1:  r = 32'd445687602;
                5'd2:  r = 32'd235489088;
                5'd3:  r = 32'd119537938;
                5'd4:  r = 32'd60000934;
                5'd5:  r = 32'd30029717;
                5'd6:  r = 32'd15018523;
                5'd7:  r = 32'd7509720;
                5'd8:  r = 32'd3754917;
                5'd9:  r = 32'd1877466;
                5'd10: r = 32'd938734;
                5'd11: r = 32'd469367;
                5'd12: r = 32'd234683;
                5'd13: r = 32'd117342;
                5'd14: r = 32'd58671;
                5'd15: r = 32'd29335;
                5'd16: r = 32'd14668;
                5'd17: r = 32'd7334;
                5'd18: r = 32'd3667;
                5'd19: r = 32'd1833;
                5'd20: r = 32'd917;
                5'd21: r = 32'd458;
                5'd22: r = 32'd229;
                5'd23: r = 32'd115;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

### design/fcpu_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fcpu_cordic
// Iterative rotation-mode cordic, one micro-rotation a cycle, giving the
// cosine and sine of an angle in 1/128 degree as clamped Q1.14.
// ---------------------------------------------------------------------------
module fcpu_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                start,
    input  wire signed [16:0]  angle,
    output logic               done,
    output logic signed [15:0] cos_out,
    output logic signed [15:0] sin_out
);
    import fcpu_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    logic               busy_reg, busy_next;
    logic [4:0]         step_reg, step_next;
    logic               neg_reg, neg_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               done_reg, done_next;

    logic signed [16:0] a_fold;
    logic               a_neg;
    logic signed [33:0] xs, ys, zt;
    logic signed [33:0] xr, yr;
    logic signed [17:0] xq, yq;
    logic signed [15:0] xc, yc;

    // fold angle into +-90 degrees
    always_comb begin
        a_fold = angle;
        a_neg  = 1'b0;
        if (angle > QUARTER) begin
            a_fold = angle - (QUARTER <<< 1);
            a_neg  = 1'b1;
        end else if (angle < -QUARTER) begin
            a_fold = angle + (QUARTER <<< 1);
            a_neg  = 1'b1;
        end
    end

    // one micro-rotation, arithmetic shift is floor division
    always_comb begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        zt = $signed({2'b00, atan_deg24(step_reg)});
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start) begin
            x_next = INV_GAIN;
            y_next = '0;
            z_next = 34'(a_fold) <<< 17;
            step_next = '0;
            neg_next  = a_neg;
            busy_next = (NSTEP != 0);
            done_next = (NSTEP == 0);
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - zt;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + zt;
            end
            step_next = step_reg + 5'd1;
            if (32'(step_reg) == NSTEP - 1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        neg_reg  <= neg_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // round by 2^16, clamp, apply fold sign
    always_comb begin
        xr = (x_reg + 34'sd32768) >>> 16;
        yr = (y_reg + 34'sd32768) >>> 16;
        xq = xr[17:0];
        yq = yr[17:0];
        if (xr > 34'sd16384)       xc = UNIT_VAL;
        else if (xr < -34'sd16384) xc = -UNIT_VAL;
        else                       xc = xq[15:0];
        if (yr > 34'sd16384)       yc = UNIT_VAL;
        else if (yr < -34'sd16384) yc = -UNIT_VAL;
        else                       yc = yq[15:0];
        cos_out = neg_reg ? -xc : xc;
        sin_out = neg_reg ? -yc : yc;
    end

    assign done = done_reg;

endmodule
`default_nettype wire

### design/fly_camera_pose_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fly_camera_pose_update
// Fly camera pose: mouse look rebuilds the basis vectors from cordic sine
// and cosine, key moves step the saturating position along them.
// ---------------------------------------------------------------------------
// channel | direction | content
// s_axis  | in        | tuser cmd; tdata key_mask, delta_time, mouse_dx, mouse_dy
// m_axis  | out       | pose: position, front, up, right
// cfg     | in        | register index and write data
//
// A look item runs two cordic passes, the yaw wrap steps and the products
// of the shared multiplier. A move item steps the position along the three
// axes of each pressed key and passes over each released key. One item is in
// work at a time; s_tready is low until the pose result has been taken.
// Reset restores the initial pose and defaults.
// ---------------------------------------------------------------------------
module fly_camera_pose_update #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [0] cmd
    input  wire         s_tuser,
    // [5:0] key_mask, [21:6] delta_time, [33:22] mouse_dx,
    // [45:34] mouse_dy, [47:46] zero
    input  wire  [47:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [111:96] front_x,
    // [127:112] front_y, [143:128] front_z, [159:144] up_x,
    // [175:160] up_y, [191:176] up_z, [207:192] right_x,
    // [223:208] right_y, [239:224] right_z
    output logic [239:0] m_tdata,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data
);
    import fcpu_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ANGLE  = 4'd1;
    localparam logic [3:0] ST_YAW    = 4'd2;
    localparam logic [3:0] ST_YAWW   = 4'd3;
    localparam logic [3:0] ST_PITCH  = 4'd4;
    localparam logic [3:0] ST_PITCHW = 4'd5;
    localparam logic [3:0] ST_VEC    = 4'd6;
    localparam logic [3:0] ST_SPEED  = 4'd7;
    localparam logic [3:0] ST_MOVE   = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;
    localparam logic [3:0] ST_WRAP   = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [15:0]        speed_cfg_reg, sens_cfg_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] front_reg [3];
    logic signed [15:0] up_reg [3];
    logic signed [15:0] right_reg [3];
    logic signed [16:0] yaw_reg, pitch_reg;
    logic signed [19:0] yaw_acc_reg;
    logic signed [15:0] cy_reg, sy_reg;
    logic [5:0]         keys_reg;
    logic [15:0]        dt_reg;
    logic signed [11:0] dx_reg, dy_reg;
    logic [31:0]        speed_reg;
    logic [2:0]         key_reg;
    logic [1:0]         comp_reg;
    logic [2:0]         vstep_reg;
    logic               in_fire;

    // shared multiplier: 33 x 17 signed, registered product
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] prod_reg;
    logic               cdc_start, cdc_done;
    logic signed [16:0] cdc_angle;
    logic signed [15:0] cdc_cos, cdc_sin;

    fcpu_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cdc_start), .angle(cdc_angle),
        .done(cdc_done), .cos_out(cdc_cos), .sin_out(cdc_sin)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign in_fire   = s_tvalid && s_tready;

    // multiply step selection: vec stage uses step counter, move uses key/comp
    logic signed [15:0] mv_comp;
    logic               mv_minus;
    always_comb begin
        mv_comp = front_reg[comp_reg];
        if (key_reg == 3'd2 || key_reg == 3'd3)      mv_comp = right_reg[comp_reg];
        else if (key_reg == 3'd4 || key_reg == 3'd5) mv_comp = up_reg[comp_reg];
        mv_minus = (key_reg == 3'd1) || (key_reg == 3'd2) || (key_reg == 3'd5);
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_ANGLE: begin
                mul_a = 33'(dx_reg);
                mul_b = $signed({1'b0, sens_cfg_reg});
            end
            ST_YAW: begin
                mul_a = 33'(dy_reg);
                mul_b = $signed({1'b0, sens_cfg_reg});
            end
            ST_VEC: begin
                // cp and sp held in up_reg[1]/front_reg[1] scratch below
                unique case (vstep_reg)
                    3'd0:    begin mul_a = 33'(cy_reg); mul_b = 17'(up_reg[1]); end
                    3'd1:    begin mul_a = 33'(sy_reg); mul_b = 17'(up_reg[1]); end
                    3'd2:    begin mul_a = 33'(-cy_reg); mul_b = 17'(front_reg[1]); end
                    default: begin mul_a = 33'(-sy_reg); mul_b = 17'(front_reg[1]); end
                endcase
            end
            ST_SPEED: begin
                mul_a = $signed({17'd0, speed_cfg_reg});
                mul_b = $signed({1'b0, dt_reg});
            end
            ST_MOVE: begin
                mul_a = $signed({1'b0, speed_reg});
                mul_b = 17'(mv_comp);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounded quantities from the registered product
    logic signed [49:0] r9, r14, r22;
    logic signed [19:0] yaw_sum;
    logic               yaw_fits;
    logic signed [19:0] pit_sum;
    logic signed [33:0] pos_sum;
    logic signed [31:0] pos_sat;
    always_comb begin
        r9  = (prod_reg + 50'sd256) >>> 9;
        r14 = (prod_reg + 50'sd8192) >>> 14;
        r22 = (prod_reg + 50'sd2097152) >>> 22;
        // mouse delta reaches about 2^18, so the sum may lie several turns out
        yaw_sum  = 20'(yaw_reg) + 20'(r9);
        yaw_fits = (yaw_acc_reg < 20'(YAW_HALF)) && (yaw_acc_reg >= -20'(YAW_HALF));
        pit_sum  = 20'(pitch_reg) - 20'(r9);
        pos_sum = mv_minus ? 34'(pos_reg[comp_reg]) - 34'(r22)
                           : 34'(pos_reg[comp_reg]) + 34'(r22);
        if (pos_sum > 34'sd2147483647)       pos_sat = 32'sh7FFFFFFF;
        else if (pos_sum < -34'sd2147483648) pos_sat = 32'sh80000000;
        else                                 pos_sat = pos_sum[31:0];
    end

    // sequencer
    logic do_key;
    always_comb begin
        state_next = state_reg;
        cdc_start  = 1'b0;
        cdc_angle  = yaw_reg;
        do_key     = (key_reg < 3'd6) && keys_reg[key_reg];
        unique case (state_reg)
            ST_IDLE:   if (in_fire) state_next = s_tuser == CMD_LOOK ? ST_ANGLE : ST_SPEED;
            ST_ANGLE:  state_next = ST_YAW;
            ST_YAW:    state_next = ST_YAWW;
            ST_YAWW:   state_next = ST_WRAP;
            ST_WRAP: begin
                if (yaw_fits) begin
                    cdc_start  = 1'b1;
                    cdc_angle  = yaw_acc_reg[16:0];
                    state_next = ST_PITCH;
                end
            end
            ST_PITCH:  if (cdc_done) state_next = ST_PITCHW;
            ST_PITCHW: begin
                cdc_angle = pitch_reg;
                if (vstep_reg == 3'd0) cdc_start = 1'b1;
                else if (cdc_done) state_next = ST_VEC;
            end
            ST_VEC:    if (vstep_reg == 3'd4) state_next = ST_OUT;
            ST_SPEED:  state_next = ST_MOVE;
            ST_MOVE: begin
                if (key_reg == 3'd6) state_next = ST_OUT;
            end
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 50'(mul_a) * 50'(mul_b);
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            speed_cfg_reg <= 16'd640;
            sens_cfg_reg  <= 16'd6554;
            for (int j = 0; j < 3; j++) begin
                pos_reg[j]   <= '0;
                front_reg[j] <= '0;
                up_reg[j]    <= '0;
                right_reg[j] <= '0;
            end
            front_reg[2] <= -UNIT_VAL;
            up_reg[1]    <= UNIT_VAL;
            right_reg[0] <= UNIT_VAL;
            yaw_reg      <= -QUARTER;
            yaw_acc_reg  <= '0;
            pitch_reg    <= '0;
            vstep_reg    <= '0;
            key_reg      <= '0;
            comp_reg     <= '0;
        end else begin
            state_reg <= state_next;
            // register writes
            if (cfg_valid) begin
                if (cfg_index == REG_MOVE_SPEED) speed_cfg_reg <= cfg_data;
                else                             sens_cfg_reg  <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    keys_reg  <= s_tdata[5:0];
                    dt_reg    <= s_tdata[21:6];
                    dx_reg    <= s_tdata[33:22];
                    dy_reg    <= s_tdata[45:34];
                    vstep_reg <= '0;
                    key_reg   <= '0;
                    comp_reg  <= '0;
                end
                ST_YAW:  yaw_acc_reg <= yaw_sum;
                ST_YAWW: begin
                    if (pit_sum > 20'(PITCH_LIMIT))       pitch_reg <= PITCH_LIMIT;
                    else if (pit_sum < -20'(PITCH_LIMIT)) pitch_reg <= -PITCH_LIMIT;
                    else                                  pitch_reg <= pit_sum[16:0];
                end
                // one turn per cycle until the yaw lies in [-180,180)
                ST_WRAP: begin
                    if (yaw_acc_reg >= 20'(YAW_HALF))
                        yaw_acc_reg <= yaw_acc_reg - 20'(YAW_FULL);
                    else if (yaw_acc_reg < -20'(YAW_HALF))
                        yaw_acc_reg <= yaw_acc_reg + 20'(YAW_FULL);
                    else
                        yaw_reg <= yaw_acc_reg[16:0];
                end
                ST_PITCH: if (cdc_done) begin
                    cy_reg <= cdc_cos;
                    sy_reg <= cdc_sin;
                end
                ST_PITCHW: begin
                    if (vstep_reg == 3'd0) vstep_reg <= 3'd1;
                    else if (cdc_done) begin
                        up_reg[1]    <= cdc_cos;
                        front_reg[1] <= cdc_sin;
                        right_reg[0] <= -sy_reg;
                        right_reg[1] <= '0;
                        right_reg[2] <= cy_reg;
                        vstep_reg    <= '0;
                    end
                end
                ST_VEC: begin
                    vstep_reg <= vstep_reg + 3'd1;
                    unique case (vstep_reg)
                        3'd1:    front_reg[0] <= r14[15:0];
                        3'd2:    front_reg[2] <= r14[15:0];
                        3'd3:    up_reg[0]    <= r14[15:0];
                        3'd4:    up_reg[2]    <= r14[15:0];
                        default: ;
                    endcase
                end
                ST_SPEED: ;
                ST_MOVE: begin
                    // speed product lands in the cycle after ST_SPEED
                    if (key_reg == 3'd0 && comp_reg == 2'd0 && vstep_reg == 3'd0) begin
                        speed_reg <= prod_reg[31:0];
                        vstep_reg <= 3'd1;
                    end else if (key_reg == 3'd6) begin
                        vstep_reg <= 3'd1;
                    end else if (!do_key) begin
                        key_reg   <= key_reg + 3'd1;
                        vstep_reg <= 3'd1;
                    end else if (vstep_reg == 3'd1) begin
                        // product valid next cycle
                        vstep_reg <= 3'd2;
                    end else begin
                        pos_reg[comp_reg] <= pos_sat;
                        vstep_reg <= 3'd1;
                        if (comp_reg == 2'd2) begin
                            comp_reg <= '0;
                            key_reg  <= key_reg + 3'd1;
                        end else begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tdata = {right_reg[2], right_reg[1], right_reg[0],
                      up_reg[2], up_reg[1], up_reg[0],
                      front_reg[2], front_reg[1], front_reg[0],
                      pos_reg[2], pos_reg[1], pos_reg[0]};

endmodule
`default_nettype wire
